// ===== hdl/psp_pkg.sv =====
// Shared types, constants and helpers for the pixel scale / swizzle / premultiply block.
// Used by every module under hdl; depends on nothing else.
`timescale 1ns / 1ps
package psp_pkg;

    localparam int MAX_DIM     = 8192;
    localparam int DIM_W       = 14;
    localparam int COORD_W     = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 14;
    localparam int DIV_STEPS   = 14;
    localparam int QUEUE_DEPTH = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd3;

    // pixel format codes
    localparam logic [1:0] FMT_RGBA        = 2'd0;
    localparam logic [1:0] FMT_RGBX        = 2'd1;
    localparam logic [1:0] FMT_BGRA        = 2'd2;
    localparam logic [1:0] FMT_UNSUPPORTED = 2'd3;

    localparam logic [DIM_W-1:0] RST_SRC_WIDTH    = 14'd1;
    localparam logic [DIM_W-1:0] RST_SRC_HEIGHT   = 14'd1;
    localparam logic [DIM_W-1:0] RST_WIDTH_LIMIT  = 14'd1600;
    localparam logic [1:0]       RST_PIXEL_FORMAT = FMT_RGBA;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
        logic       frame_start;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0]         out_red;
        logic [7:0]         out_green;
        logic [7:0]         out_blue;
        logic [COORD_W-1:0] out_col;
        logic [COORD_W-1:0] out_row;
        logic [DIM_W-1:0]   frame_width_out;
        logic [DIM_W-1:0]   frame_height_out;
        logic               format_error;
    } pixel_out_t;

    typedef struct packed {
        logic [DIM_W-1:0] src_width;
        logic [DIM_W-1:0] src_height;
        logic [DIM_W-1:0] width_limit;
        logic [1:0]       pixel_format;
    } cfg_t;

    // one selected pixel on its way from the front to the back
    typedef struct packed {
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic               format_error;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
    } q_entry_t;

    // divider request: quotient of d * src / divisor, known to stay below 2**DIV_STEPS
    typedef struct packed {
        logic             start;
        logic [DIM_W-1:0] d;
        logic [DIM_W-1:0] src;
        logic [DIM_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_STEPS-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_HDIV,
        FS_EVAL,
        FS_PDIV
    } front_state_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > DIM_W'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== hdl/psp_divider.sv =====
// Sequential restoring divider: floor(d * src / divisor), one quotient bit a cycle.
// Depends on psp_pkg.
`timescale 1ns / 1ps
module psp_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  psp_pkg::div_req_t req,
    output psp_pkg::div_rsp_t rsp
);
    import psp_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [DIM_W-1:0]     rem_reg, rem_next;
    logic [DIV_STEPS-1:0] num_reg, num_next;
    logic [DIM_W-1:0]     divisor_reg, divisor_next;
    logic [2*DIM_W-1:0]   prod;
    logic [DIM_W:0]       shifted;
    logic [DIM_W:0]       trial;
    logic                 fits;

    assign prod    = (2*DIM_W)'(req.d) * (2*DIM_W)'(req.src);
    assign shifted = {rem_reg, num_reg[DIV_STEPS-1]};
    assign trial   = shifted - {1'b0, divisor_reg};
    assign fits    = shifted >= {1'b0, divisor_reg};

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        rem_next     = rem_reg;
        num_next     = num_reg;
        divisor_next = divisor_reg;
        if (req.start)
        begin
            // quotient stays below 2**DIV_STEPS, so the upper half already lies below the divisor
            busy_next    = 1'b1;
            count_next   = '0;
            rem_next     = prod[2*DIM_W-1:DIV_STEPS];
            num_next     = prod[DIV_STEPS-1:0];
            divisor_next = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[DIM_W-1:0] : shifted[DIM_W-1:0];
            num_next = {num_reg[DIV_STEPS-2:0], fits};
            if (count_reg == CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        num_reg     <= num_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = num_reg;

endmodule

// ===== hdl/psp_front.sv =====
// Front part: accepts source pixels, tracks source and output position, selects
// nearest-neighbour pixels and swizzles them into the queue. Depends on psp_pkg.
`timescale 1ns / 1ps
module psp_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_ready,
    input  psp_pkg::pixel_in_t src_pixel,
    input  psp_pkg::cfg_t      cfg,
    input  logic               q_full,
    output logic               q_push,
    output psp_pkg::q_entry_t  q_entry,
    output psp_pkg::div_req_t  div_req,
    input  psp_pkg::div_rsp_t  div_rsp
);
    import psp_pkg::*;

    localparam logic [DIM_W-1:0] SRC_ROW_SAT = '1;

    front_state_t fsm_reg, fsm_next;
    pixel_in_t    item_reg, item_next;
    logic         pend_row_reg, pend_row_next;

    logic [COORD_W-1:0] src_col_reg, src_col_next;
    logic [DIM_W-1:0]   src_row_reg, src_row_next;
    logic [DIM_W-1:0]   dst_col_reg, dst_col_next;
    logic [DIM_W-1:0]   dst_row_reg, dst_row_next;
    logic [COORD_W-1:0] next_col_reg, next_col_next;
    logic [COORD_W-1:0] next_row_reg, next_row_next;
    logic [DIM_W-1:0]   scaled_w_reg, scaled_w_next;
    logic [DIM_W-1:0]   scaled_h_reg, scaled_h_next;

    logic [DIM_W-1:0] sw, sh, lim, ow;
    logic             accept, fs_now, need_hdiv;

    pixel_in_t          e_item;
    logic [COORD_W-1:0] e_src_col, e_next_col, e_next_row;
    logic [DIM_W-1:0]   e_src_row, e_dst_col, e_dst_row, e_sw, e_sh;
    logic               row_live, keep, row_end;
    logic [DIM_W-1:0]   src_col_inc, col_inc, row_inc;

    logic [COORD_W-1:0] ev_src_col, ev_next_col, ev_next_row;
    logic [DIM_W-1:0]   ev_src_row, ev_dst_col, ev_dst_row;
    logic               ev_div, ev_div_row;
    logic [DIM_W-1:0]   ev_d, ev_src, ev_divisor;

    assign sw  = clamp_dim(cfg.src_width);
    assign sh  = clamp_dim(cfg.src_height);
    assign lim = clamp_dim(cfg.width_limit);
    assign ow  = (sw < lim) ? sw : lim;

    assign src_ready = (fsm_reg == FS_IDLE) && !q_full;
    assign accept    = src_valid && src_ready;
    assign fs_now    = (fsm_reg == FS_IDLE) && src_pixel.frame_start;
    assign need_hdiv = fs_now && (ow != sw);

    // state as seen by the pixel under evaluation: a frame start clears it first
    always_comb
    begin
        e_item = (fsm_reg == FS_EVAL) ? item_reg : src_pixel;
        if (fs_now)
        begin
            e_src_col  = '0;
            e_src_row  = '0;
            e_dst_col  = '0;
            e_dst_row  = '0;
            e_next_col = '0;
            e_next_row = '0;
            e_sw       = ow;
            e_sh       = sh;
        end
        else
        begin
            e_src_col  = src_col_reg;
            e_src_row  = src_row_reg;
            e_dst_col  = dst_col_reg;
            e_dst_row  = dst_row_reg;
            e_next_col = next_col_reg;
            e_next_row = next_row_reg;
            e_sw       = scaled_w_reg;
            e_sh       = scaled_h_reg;
        end
    end

    assign row_live    = (e_dst_row < e_sh) && (e_src_row == {1'b0, e_next_row});
    assign keep        = row_live && (e_dst_col < e_sw) && (e_src_col == e_next_col);
    assign src_col_inc = {1'b0, e_src_col} + DIM_W'(1);
    assign row_end     = src_col_inc >= sw;
    assign col_inc     = e_dst_col + DIM_W'(1);
    assign row_inc     = e_dst_row + DIM_W'(1);

    // counter update; a pick equal to the index needs no division
    always_comb
    begin
        ev_src_col  = e_src_col;
        ev_src_row  = e_src_row;
        ev_dst_col  = e_dst_col;
        ev_dst_row  = e_dst_row;
        ev_next_col = e_next_col;
        ev_next_row = e_next_row;
        ev_div      = 1'b0;
        ev_div_row  = 1'b0;
        ev_d        = col_inc;
        ev_src      = sw;
        ev_divisor  = e_sw;
        if (row_end)
        begin
            ev_src_col  = '0;
            ev_dst_col  = '0;
            ev_next_col = '0;
            ev_src_row  = (e_src_row == SRC_ROW_SAT) ? e_src_row : e_src_row + DIM_W'(1);
            if (row_live)
            begin
                ev_dst_row = row_inc;
                if (row_inc < e_sh)
                begin
                    if (sh == e_sh)
                    begin
                        ev_next_row = row_inc[COORD_W-1:0];
                    end
                    else
                    begin
                        ev_div     = 1'b1;
                        ev_div_row = 1'b1;
                        ev_d       = row_inc;
                        ev_src     = sh;
                        ev_divisor = e_sh;
                    end
                end
            end
        end
        else
        begin
            ev_src_col = src_col_inc[COORD_W-1:0];
            if (keep)
            begin
                ev_dst_col = col_inc;
                if (col_inc < e_sw)
                begin
                    if (sw == e_sw)
                    begin
                        ev_next_col = col_inc[COORD_W-1:0];
                    end
                    else
                    begin
                        ev_div = 1'b1;
                    end
                end
            end
        end
    end

    // swizzle and alpha handling of the selected pixel
    always_comb
    begin
        q_entry.green        = e_item.byte1;
        q_entry.red          = (cfg.pixel_format == FMT_BGRA) ? e_item.byte2 : e_item.byte0;
        q_entry.blue         = (cfg.pixel_format == FMT_BGRA) ? e_item.byte0 : e_item.byte2;
        q_entry.alpha        = (cfg.pixel_format == FMT_RGBX) ? 8'd255 : e_item.byte3;
        q_entry.format_error = (cfg.pixel_format == FMT_UNSUPPORTED);
        q_entry.col          = e_dst_col[COORD_W-1:0];
        q_entry.row          = e_dst_row[COORD_W-1:0];
        q_entry.width        = e_sw;
        q_entry.height       = e_sh;
    end

    always_comb
    begin
        fsm_next      = fsm_reg;
        item_next     = item_reg;
        pend_row_next = pend_row_reg;
        src_col_next  = src_col_reg;
        src_row_next  = src_row_reg;
        dst_col_next  = dst_col_reg;
        dst_row_next  = dst_row_reg;
        next_col_next = next_col_reg;
        next_row_next = next_row_reg;
        scaled_w_next = scaled_w_reg;
        scaled_h_next = scaled_h_reg;
        q_push        = 1'b0;
        div_req       = '0;
        case (fsm_reg)
            FS_IDLE:
            begin
                if (accept)
                begin
                    item_next = src_pixel;
                    if (need_hdiv)
                    begin
                        // reduced width: the output height needs a division first
                        src_col_next    = '0;
                        src_row_next    = '0;
                        dst_col_next    = '0;
                        dst_row_next    = '0;
                        next_col_next   = '0;
                        next_row_next   = '0;
                        scaled_w_next   = ow;
                        div_req.start   = 1'b1;
                        div_req.d       = ow;
                        div_req.src     = sh;
                        div_req.divisor = sw;
                        fsm_next        = FS_HDIV;
                    end
                    else
                    begin
                        src_col_next  = ev_src_col;
                        src_row_next  = ev_src_row;
                        dst_col_next  = ev_dst_col;
                        dst_row_next  = ev_dst_row;
                        next_col_next = ev_next_col;
                        next_row_next = ev_next_row;
                        scaled_w_next = e_sw;
                        scaled_h_next = e_sh;
                        q_push        = keep;
                        if (ev_div)
                        begin
                            div_req.start   = 1'b1;
                            div_req.d       = ev_d;
                            div_req.src     = ev_src;
                            div_req.divisor = ev_divisor;
                            pend_row_next   = ev_div_row;
                            fsm_next        = FS_PDIV;
                        end
                    end
                end
            end
            FS_HDIV:
            begin
                if (div_rsp.done)
                begin
                    scaled_h_next = (div_rsp.quotient == '0) ? DIM_W'(1) : div_rsp.quotient;
                    fsm_next      = FS_EVAL;
                end
            end
            FS_EVAL:
            begin
                if (!q_full)
                begin
                    src_col_next  = ev_src_col;
                    src_row_next  = ev_src_row;
                    dst_col_next  = ev_dst_col;
                    dst_row_next  = ev_dst_row;
                    next_col_next = ev_next_col;
                    next_row_next = ev_next_row;
                    q_push        = keep;
                    if (ev_div)
                    begin
                        div_req.start   = 1'b1;
                        div_req.d       = ev_d;
                        div_req.src     = ev_src;
                        div_req.divisor = ev_divisor;
                        pend_row_next   = ev_div_row;
                        fsm_next        = FS_PDIV;
                    end
                    else
                    begin
                        fsm_next = FS_IDLE;
                    end
                end
            end
            FS_PDIV:
            begin
                if (div_rsp.done)
                begin
                    if (pend_row_reg)
                    begin
                        next_row_next = div_rsp.quotient[COORD_W-1:0];
                    end
                    else
                    begin
                        next_col_next = div_rsp.quotient[COORD_W-1:0];
                    end
                    fsm_next = FS_IDLE;
                end
            end
            default:
            begin
                fsm_next = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg      <= FS_IDLE;
            pend_row_reg <= 1'b0;
            src_col_reg  <= '0;
            src_row_reg  <= '0;
            dst_col_reg  <= '0;
            dst_row_reg  <= '0;
            next_col_reg <= '0;
            next_row_reg <= '0;
            scaled_w_reg <= DIM_W'(1);
            scaled_h_reg <= DIM_W'(1);
        end
        else
        begin
            fsm_reg      <= fsm_next;
            pend_row_reg <= pend_row_next;
            src_col_reg  <= src_col_next;
            src_row_reg  <= src_row_next;
            dst_col_reg  <= dst_col_next;
            dst_row_reg  <= dst_row_next;
            next_col_reg <= next_col_next;
            next_row_reg <= next_row_next;
            scaled_w_reg <= scaled_w_next;
            scaled_h_reg <= scaled_h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

// ===== hdl/psp_fifo.sv =====
// Short queue of selected pixels between the front and the back part.
// Depends on psp_pkg.
`timescale 1ns / 1ps
module psp_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  psp_pkg::q_entry_t push_entry,
    input  logic              pop,
    output psp_pkg::q_entry_t head,
    output logic              full,
    output logic              empty
);
    import psp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_entry_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hdl/psp_back.sv =====
// Back part: premultiplies colour by alpha (colour is zero on a format error) and
// holds the result in the output register. Depends on psp_pkg.
`timescale 1ns / 1ps
module psp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  psp_pkg::q_entry_t   q_head,
    output logic                q_pop,
    output logic                dst_valid,
    input  logic                dst_ready,
    output psp_pkg::pixel_out_t dst_pixel
);
    import psp_pkg::*;

    logic       out_valid_reg, out_valid_next;
    pixel_out_t out_reg, out_next;

    // (c * a + 127) / 255, with the division as x + (x >> 8) + 1, then >> 8
    function automatic logic [7:0] premul(input logic [7:0] c, input logic [7:0] a);
        logic [15:0] x;
        logic [15:0] s;
        x = 16'(c) * 16'(a) + 16'd127;
        s = x + {8'd0, x[15:8]} + 16'd1;
        return s[15:8];
    endfunction

    assign q_pop = !q_empty && (!out_valid_reg || dst_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (q_pop)
        begin
            out_valid_next            = 1'b1;
            out_next.out_red          = q_head.format_error ? 8'd0
                                                            : premul(q_head.red, q_head.alpha);
            out_next.out_green        = q_head.format_error ? 8'd0
                                                            : premul(q_head.green, q_head.alpha);
            out_next.out_blue         = q_head.format_error ? 8'd0
                                                            : premul(q_head.blue, q_head.alpha);
            out_next.out_col          = q_head.col;
            out_next.out_row          = q_head.row;
            out_next.frame_width_out  = q_head.width;
            out_next.frame_height_out = q_head.height;
            out_next.format_error     = q_head.format_error;
        end
        else if (dst_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign dst_valid = out_valid_reg;
    assign dst_pixel = out_reg;

endmodule

// ===== hdl/pixel_scale_swizzle_premultiply_top.sv =====
// Top level of the nearest-neighbour downscaler with channel swizzle and alpha premultiply.
// Depends on psp_pkg, psp_divider, psp_front, psp_fifo and psp_back.
//
//   Port group  Dir  Handshake            Payload
//   src_*       in   src_valid/src_ready  src_pixel (pixel_in_t)
//   dst_*       out  dst_valid/dst_ready  dst_pixel (pixel_out_t)
//   cfg_*       in   cfg_write            cfg_index, cfg_data
//
// One pixel a cycle while no output dimension is reduced and the queue is not full.
// A frame start that narrows the width first waits for the output height division.
// Where a dimension is reduced, each pixel that needs a new pick waits for the
// shared 14-step divider, which runs while the front holds src_ready low.
// Reset clears all position counters and sets a 1x1 output; no clearing pass.
// A stalled output fills the 2-entry queue, after which the front stops accepting.
`timescale 1ns / 1ps
module pixel_scale_swizzle_premultiply_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                src_valid,
    output logic                                src_ready,
    input  psp_pkg::pixel_in_t                  src_pixel,
    output logic                                dst_valid,
    input  logic                                dst_ready,
    output psp_pkg::pixel_out_t                 dst_pixel,
    input  logic                                cfg_write,
    input  logic [psp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [psp_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import psp_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    logic      q_push, q_pop, q_full, q_empty;
    q_entry_t  q_in, q_head;
    div_req_t  div_req;
    div_rsp_t  div_rsp;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_SRC_WIDTH:    cfg_next.src_width    = cfg_data[DIM_W-1:0];
                REG_SRC_HEIGHT:   cfg_next.src_height   = cfg_data[DIM_W-1:0];
                REG_WIDTH_LIMIT:  cfg_next.width_limit  = cfg_data[DIM_W-1:0];
                REG_PIXEL_FORMAT: cfg_next.pixel_format = cfg_data[1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_width    <= RST_SRC_WIDTH;
            cfg_reg.src_height   <= RST_SRC_HEIGHT;
            cfg_reg.width_limit  <= RST_WIDTH_LIMIT;
            cfg_reg.pixel_format <= RST_PIXEL_FORMAT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    psp_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    psp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_pixel (src_pixel),
        .cfg       (cfg_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_in),
        .div_req   (div_req),
        .div_rsp   (div_rsp)
    );

    psp_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .head       (q_head),
        .full       (q_full),
        .empty      (q_empty)
    );

    psp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_pixel (dst_pixel)
    );

endmodule
